// ===== rtl/core/tlj_pkg.sv =====
// ----------------------------------------------------------------------------
// tlj_pkg
// Shared types and codes for the tree LCA / level-ancestor unit: beat
// payloads, the per-node record, and the buses between controller and datapath.
// ----------------------------------------------------------------------------
package tlj_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 10;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [OP_W-1:0]    op_t;
  typedef logic [ST_W-1:0]    status_t;

  // Opcodes
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_LCA    = 2'd1;
  localparam op_t OP_KTH    = 2'd2;

  // Result status
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_ABSENT    = 2'd1;
  localparam status_t ST_DUPLICATE = 2'd2;
  localparam status_t ST_TOO_FAR   = 2'd3;

  // Read address select
  localparam logic [2:0] RD_A  = 3'd0;  // node_a
  localparam logic [2:0] RD_B  = 3'd1;  // node_b
  localparam logic [2:0] RD_J  = 3'd2;  // jump of the parent record
  localparam logic [2:0] RD_NV = 3'd3;  // next node of a climb step
  localparam logic [2:0] RD_NX = 3'd4;  // next x of a lockstep step
  localparam logic [2:0] RD_Y  = 3'd5;  // current y

  // Result select
  localparam logic [2:0] RES_ERR   = 3'd0;
  localparam logic [2:0] RES_ROOT  = 3'd1;
  localparam logic [2:0] RES_CHILD = 3'd2;
  localparam logic [2:0] RES_Y     = 3'd3;
  localparam logic [2:0] RES_X     = 3'd4;
  localparam logic [2:0] RES_PAR   = 3'd5;

  typedef struct packed {
    op_t    opcode;
    node_t  node_a;
    node_t  node_b;
    logic   is_root;
    depth_t count_k;
  } req_t;

  typedef struct packed {
    node_t   result_node;
    depth_t  result_depth;
    status_t status;
  } rsp_t;

  // Per-node record; jdep caches the depth of the jump target
  typedef struct packed {
    node_t  parent;
    depth_t depth;
    node_t  jump;
    depth_t jdep;
  } rec_t;

  typedef struct packed {
    logic       load_in;
    logic       clr_en;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       lat_x;
    logic       lat_y;
    logic       lat_pa;
    logic       lat_pb;
    logic       wr_root;
    logic       wr_child;
    logic       setup_lca;
    logic       setup_kth;
    logic       climb_step;
    logic       lca_step;
    logic       res_load;
    logic [2:0] res_kind;
    status_t    res_status;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic is_root;
    logic a_in;
    logic pres_a;
    logic a_ok;
    logic b_ok;
    logic root_seen;
    logic k_too_far;
    logic kk_zero;
    logic x_eq_y;
    logic par_eq;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

// ===== rtl/core/tlj_chan_if.sv =====
// ----------------------------------------------------------------------------
// tlj_chan_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface tlj_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tlj_dpath.sv =====
// ----------------------------------------------------------------------------
// tlj_dpath
// Datapath: node record and presence memories, working registers for the
// climb and lockstep walks, result and output registers.
// ----------------------------------------------------------------------------
module tlj_dpath #(
  parameter int MAX_NODES = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  tlj_pkg::req_t req_data,
  input  tlj_pkg::cmd_t cmd,
  output tlj_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output tlj_pkg::rsp_t out_data
);

  localparam int DEPTH_N = (MAX_NODES < 1024) ? MAX_NODES : 1024;
  localparam int IDX_W   = $clog2(DEPTH_N);

  // Latched item
  tlj_pkg::op_t    op;
  tlj_pkg::node_t  a;
  tlj_pkg::node_t  b;
  logic            root_f;
  tlj_pkg::depth_t k;

  // Walk state
  tlj_pkg::node_t  vx;
  tlj_pkg::node_t  vy;
  tlj_pkg::depth_t kk;
  tlj_pkg::rec_t   rx;
  tlj_pkg::rec_t   ry;
  logic            pres_a;
  logic            pres_b;
  logic            root_seen;
  logic [IDX_W-1:0] clr_idx;

  // Results
  tlj_pkg::rsp_t   res;

  // Memories
  tlj_pkg::rec_t   rec_mem [DEPTH_N];
  logic            pres_mem [DEPTH_N];
  tlj_pkg::rec_t   rec_q;
  logic            pres_q;

  logic            a_in;
  logic            b_in;
  tlj_pkg::depth_t gap;
  logic            take_jump;
  tlj_pkg::node_t  nv;
  tlj_pkg::depth_t kk_dec;
  logic            jump_eq;
  tlj_pkg::node_t  nx;
  tlj_pkg::node_t  ny;
  logic            skew;
  tlj_pkg::rec_t   child_rec;
  tlj_pkg::rec_t   root_rec;
  tlj_pkg::node_t  rd_node;
  logic            rec_we;
  tlj_pkg::rec_t   rec_wd;
  logic            pres_we;
  logic [IDX_W-1:0] pres_wa;
  logic            pres_wd;

  // Range checks against the node table size
  assign a_in = (32'(a) < 32'(MAX_NODES));
  assign b_in = (32'(b) < 32'(MAX_NODES));

  // Climb step: jump when it does not overshoot, else take the parent
  assign gap       = ry.depth - ry.jdep;
  assign take_jump = (gap != '0) && (gap <= kk);
  assign nv        = take_jump ? ry.jump : ry.parent;
  assign kk_dec    = take_jump ? gap : tlj_pkg::depth_t'(1);

  // Lockstep step: jump both unless the jumps meet
  assign jump_eq = (rx.jump == ry.jump);
  assign nx      = jump_eq ? rx.parent : rx.jump;
  assign ny      = jump_eq ? ry.parent : ry.jump;

  // New child record; ry holds the parent, rec_q the parent's jump target
  assign skew = (({1'b0, ry.depth} + {1'b0, rec_q.jdep}) == {ry.jdep, 1'b0});
  always_comb begin
    child_rec.parent = b;
    child_rec.depth  = ry.depth + tlj_pkg::depth_t'(1);
    child_rec.jump   = skew ? rec_q.jump : b;
    child_rec.jdep   = skew ? rec_q.jdep : ry.depth;
  end

  always_comb begin
    root_rec.parent = a;
    root_rec.depth  = '0;
    root_rec.jump   = a;
    root_rec.jdep   = '0;
  end

  // Read address select
  always_comb begin
    case (cmd.rd_sel)
      tlj_pkg::RD_A:  rd_node = a;
      tlj_pkg::RD_B:  rd_node = b;
      tlj_pkg::RD_J:  rd_node = ry.jump;
      tlj_pkg::RD_NV: rd_node = nv;
      tlj_pkg::RD_NX: rd_node = nx;
      tlj_pkg::RD_Y:  rd_node = vy;
      default:        rd_node = a;
    endcase
  end

  // Write port control
  assign rec_we  = cmd.wr_root || cmd.wr_child;
  assign rec_wd  = cmd.wr_root ? root_rec : child_rec;
  assign pres_we = cmd.clr_en || cmd.wr_root || cmd.wr_child;
  assign pres_wa = cmd.clr_en ? clr_idx : a[IDX_W-1:0];
  assign pres_wd = !cmd.clr_en;

  // Record memory
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[a[IDX_W-1:0]] <= rec_wd;
    end
    if (cmd.rd_en) begin
      rec_q <= rec_mem[rd_node[IDX_W-1:0]];
    end
  end

  // Presence memory
  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_wa] <= pres_wd;
    end
    if (cmd.rd_en) begin
      pres_q <= pres_mem[rd_node[IDX_W-1:0]];
    end
  end

  // Clear sweep counter and root flag
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      root_seen <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (cmd.wr_root) begin
        root_seen <= 1'b1;
      end
    end
  end

  // Item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op     <= req_data.opcode;
      a      <= req_data.node_a;
      b      <= req_data.node_b;
      root_f <= req_data.is_root;
      k      <= req_data.count_k;
      vx     <= req_data.node_a;
      vy     <= req_data.node_b;
    end
    if (cmd.lat_pa) begin
      pres_a <= pres_q;
    end
    if (cmd.lat_pb) begin
      pres_b <= pres_q;
    end
    if (cmd.lat_x) begin
      rx <= rec_q;
    end
    if (cmd.lat_y) begin
      ry <= rec_q;
    end
    if (cmd.setup_lca) begin
      // Keep the shallower node in x
      if (rx.depth > ry.depth) begin
        vx <= vy;
        vy <= vx;
        rx <= ry;
        ry <= rx;
        kk <= rx.depth - ry.depth;
      end else begin
        kk <= ry.depth - rx.depth;
      end
    end
    if (cmd.setup_kth) begin
      vy <= a;
      ry <= rx;
      kk <= k;
    end
    if (cmd.climb_step) begin
      vy <= nv;
      kk <= kk - kk_dec;
    end
    if (cmd.lca_step) begin
      vx <= nx;
      vy <= ny;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res.status <= cmd.res_status;
      case (cmd.res_kind)
        tlj_pkg::RES_ROOT: begin
          res.result_node  <= a;
          res.result_depth <= '0;
        end
        tlj_pkg::RES_CHILD: begin
          res.result_node  <= a;
          res.result_depth <= child_rec.depth;
        end
        tlj_pkg::RES_Y: begin
          res.result_node  <= vy;
          res.result_depth <= ry.depth;
        end
        tlj_pkg::RES_X: begin
          res.result_node  <= vx;
          res.result_depth <= rx.depth;
        end
        tlj_pkg::RES_PAR: begin
          res.result_node  <= rx.parent;
          res.result_depth <= rx.depth - tlj_pkg::depth_t'(1);
        end
        default: begin
          res.result_node  <= '0;
          res.result_depth <= '0;
        end
      endcase
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  // Status to the controller
  always_comb begin
    sts.op        = op;
    sts.is_root   = root_f;
    sts.a_in      = a_in;
    sts.pres_a    = pres_a;
    sts.a_ok      = a_in && pres_a;
    sts.b_ok      = b_in && pres_b;
    sts.root_seen = root_seen;
    sts.k_too_far = (k > rx.depth);
    sts.kk_zero   = (kk == '0);
    sts.x_eq_y    = (vx == vy);
    sts.par_eq    = (rx.parent == ry.parent);
    sts.out_free  = !out_valid || out_ready;
    sts.clr_last  = (clr_idx == IDX_W'(DEPTH_N - 1));
  end

endmodule

// ===== rtl/core/tlj_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlj_ctrl
// Controller: clear sweep after reset, item fetch, checks, climb and
// lockstep walks, result handoff.
// ----------------------------------------------------------------------------
module tlj_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tlj_pkg::sts_t sts,
  output tlj_pkg::cmd_t cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_RD_A    = 4'd2;
  localparam logic [3:0] S_RD_B    = 4'd3;
  localparam logic [3:0] S_GOT_B   = 4'd4;
  localparam logic [3:0] S_DECIDE  = 4'd5;
  localparam logic [3:0] S_INS_J   = 4'd6;
  localparam logic [3:0] S_CLIMB   = 4'd7;
  localparam logic [3:0] S_CLIMB_G = 4'd8;
  localparam logic [3:0] S_LCA_CHK = 4'd9;
  localparam logic [3:0] S_LCA_STP = 4'd10;
  localparam logic [3:0] S_LCA_GX  = 4'd11;
  localparam logic [3:0] S_LCA_GY  = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      // Sweep the presence table to zero
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_RD_A;
        end
      end
      S_RD_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tlj_pkg::RD_A;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        cmd.lat_x  = 1'b1;
        cmd.lat_pa = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tlj_pkg::RD_B;
        state_next = S_GOT_B;
      end
      S_GOT_B: begin
        cmd.lat_y  = 1'b1;
        cmd.lat_pb = 1'b1;
        state_next = S_DECIDE;
      end
      // Checks and dispatch by opcode
      S_DECIDE: begin
        case (sts.op)
          tlj_pkg::OP_INSERT: begin
            if (!sts.a_in) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = tlj_pkg::ST_ABSENT;
              state_next     = S_DONE;
            end else if (sts.pres_a) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = tlj_pkg::ST_DUPLICATE;
              state_next     = S_DONE;
            end else if (sts.is_root) begin
              cmd.res_load = 1'b1;
              state_next   = S_DONE;
              if (sts.root_seen) begin
                cmd.res_status = tlj_pkg::ST_DUPLICATE;
              end else begin
                cmd.wr_root  = 1'b1;
                cmd.res_kind = tlj_pkg::RES_ROOT;
              end
            end else if (!sts.b_ok) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = tlj_pkg::ST_ABSENT;
              state_next     = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = tlj_pkg::RD_J;
              state_next = S_INS_J;
            end
          end
          tlj_pkg::OP_LCA: begin
            if (!sts.a_ok || !sts.b_ok) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = tlj_pkg::ST_ABSENT;
              state_next     = S_DONE;
            end else begin
              cmd.setup_lca = 1'b1;
              state_next    = S_CLIMB;
            end
          end
          tlj_pkg::OP_KTH: begin
            if (!sts.a_ok) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = tlj_pkg::ST_ABSENT;
              state_next     = S_DONE;
            end else if (sts.k_too_far) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = tlj_pkg::ST_TOO_FAR;
              state_next     = S_DONE;
            end else begin
              cmd.setup_kth = 1'b1;
              state_next    = S_CLIMB;
            end
          end
          default: begin
            // Unused opcode: drop the item
            state_next = S_IDLE;
          end
        endcase
      end
      // Write the child record once the parent's jump target is read
      S_INS_J: begin
        cmd.wr_child = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = tlj_pkg::RES_CHILD;
        state_next   = S_DONE;
      end
      // Climb y by the remaining count
      S_CLIMB: begin
        if (sts.kk_zero) begin
          if (sts.op == tlj_pkg::OP_KTH) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = tlj_pkg::RES_Y;
            state_next   = S_DONE;
          end else begin
            state_next = S_LCA_CHK;
          end
        end else begin
          cmd.climb_step = 1'b1;
          cmd.rd_en      = 1'b1;
          cmd.rd_sel     = tlj_pkg::RD_NV;
          state_next     = S_CLIMB_G;
        end
      end
      S_CLIMB_G: begin
        cmd.lat_y  = 1'b1;
        state_next = S_CLIMB;
      end
      S_LCA_CHK: begin
        if (sts.x_eq_y) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = tlj_pkg::RES_X;
          state_next   = S_DONE;
        end else begin
          state_next = S_LCA_STP;
        end
      end
      // Advance both nodes in lockstep until the parents meet
      S_LCA_STP: begin
        if (sts.par_eq) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = tlj_pkg::RES_PAR;
          state_next   = S_DONE;
        end else begin
          cmd.lca_step = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = tlj_pkg::RD_NX;
          state_next   = S_LCA_GX;
        end
      end
      S_LCA_GX: begin
        cmd.lat_x  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = tlj_pkg::RD_Y;
        state_next = S_LCA_GY;
      end
      S_LCA_GY: begin
        cmd.lat_y  = 1'b1;
        state_next = S_LCA_STP;
      end
      // Hand the result to the output register when it frees up
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/tree_lca_jump_pointers_unit.sv =====
// ----------------------------------------------------------------------------
// tree_lca_jump_pointers_unit
// Rooted tree store with insert, lowest common ancestor and k-th ancestor
// queries over skew-binary jump pointers.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per beat (opcode, node_a, node_b, is_root, count_k);
//   rsp returns one beat per item (result_node, result_depth, status). An
//   item with the unused opcode is taken and gives no beat.
//   Items are worked one at a time; req.ready is high only while idle.
//   Each item fetches the records of node_a and node_b, one memory read per
//   cycle; a child insert also reads the parent's jump target. A k-th
//   ancestor query then climbs; an LCA query climbs the deeper node to the
//   other's depth, then steps both in lockstep when neither node is an
//   ancestor of the other.
//   Climb and lockstep steps are O(log depth); the single read port of the
//   node record memory sets the pace of each step.
//   After reset the presence table, min(MAX_NODES, 1024) entries, is swept
//   to zero, one entry a cycle, with req.ready low.
//   A finished result sits in an output register; while rsp stalls, the
//   next item is still taken and worked, and waits only to hand over.
// ----------------------------------------------------------------------------
module tree_lca_jump_pointers_unit #(
  parameter int MAX_NODES = 1024
) (
  input logic       clk,
  input logic       rst,
  tlj_chan_if.sink   req,
  tlj_chan_if.source rsp
);

  tlj_pkg::cmd_t cmd;
  tlj_pkg::sts_t sts;
  tlj_pkg::req_t req_data;
  tlj_pkg::rsp_t rsp_data;
  logic          rsp_valid;
  logic          req_ready;

  assign req_data  = req.data;
  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  tlj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlj_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (rsp_valid),
    .out_ready (rsp.ready),
    .out_data  (rsp_data)
  );

endmodule
